// ===== hw/rtl/sampled_integral_accumulator_macros.svh =====
// assertion macros for the rtl files, included by saia_back
`ifndef SAMPLED_INTEGRAL_ACCUMULATOR_MACROS_SVH
`define SAMPLED_INTEGRAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SAIA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SAIA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/saia_pkg.sv =====
`timescale 1ns / 1ps

package saia_pkg;

  localparam int SMP_W  = 32;
  localparam int OUT_W  = 48;
  localparam int CNT_W  = 11;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 32;
  localparam int SUM_W  = 48;
  localparam int WGT_W  = 51;
  localparam int WID_W  = 33;
  localparam int PROD_W = 84;
  localparam int NUM_W  = 85;
  localparam int DEN_W  = 29;
  localparam int DCNT_W = 7;
  localparam int MAXN_W = 17;

  localparam logic [CIDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LOWER = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_UPPER = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_COUNT = 2'd3;

  typedef enum logic [1:0] {
    CLS_END,
    CLS_ODD,
    CLS_EVEN
  } class_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    class_e                  cls;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic                    mode;
    logic signed [SMP_W-1:0] lower;
    logic signed [SMP_W-1:0] upper;
    logic [CNT_W-1:0]        count;
  } cfg_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    err;
  } res_t;

  // interval count clamped to 1..maxn
  function automatic logic [CNT_W-1:0] eff_n(input logic [CNT_W-1:0] cnt,
                                              input logic [MAXN_W-1:0] maxn);
    logic [CNT_W-1:0] n;
    n = cnt;
    if (cnt == '0) begin
      n = CNT_W'(1);
    end else if ({{(MAXN_W-CNT_W){1'b0}}, cnt} > maxn) begin
      n = maxn[CNT_W-1:0];
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/saia_fifo.sv =====
`timescale 1ns / 1ps

module saia_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr, rd;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign wr      = wr_en_i && !full_o;
  assign rd      = rd_en_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr && !rd) begin
      count_d = count_q + 1'b1;
    end else if (rd && !wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/saia_front.sv =====
`timescale 1ns / 1ps

module saia_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic signed [saia_pkg::SMP_W-1:0]     sample_i,
  input  logic [saia_pkg::CNT_W-1:0]            n_i,
  output saia_pkg::item_t                       item_o
);

  logic [saia_pkg::CNT_W-1:0] idx_q, idx_d;
  logic                       last;
  saia_pkg::class_e           cls;

  assign last = (idx_q >= n_i);

  always_comb begin
    if (idx_q == '0 || last) begin
      cls = saia_pkg::CLS_END;
    end else if (idx_q[0]) begin
      cls = saia_pkg::CLS_ODD;
    end else begin
      cls = saia_pkg::CLS_EVEN;
    end
  end

  always_comb begin
    item_o.sample = sample_i;
    item_o.cls    = cls;
    item_o.last   = last;
  end

  always_comb begin
    idx_d = idx_q;
    if (accept_i) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== hw/rtl/saia_back.sv =====
`timescale 1ns / 1ps
`include "sampled_integral_accumulator_macros.svh"

module saia_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  saia_pkg::cfg_t             cfg_i,
  input  logic [saia_pkg::CNT_W-1:0] n_i,
  input  logic                       in_empty_i,
  input  saia_pkg::item_t            in_item_i,
  output logic                       in_pop_o,
  input  logic                       out_full_i,
  output logic                       res_push_o,
  output saia_pkg::res_t             res_o
);

  localparam int SUM_W  = saia_pkg::SUM_W;
  localparam int WGT_W  = saia_pkg::WGT_W;
  localparam int WID_W  = saia_pkg::WID_W;
  localparam int PROD_W = saia_pkg::PROD_W;
  localparam int NUM_W  = saia_pkg::NUM_W;
  localparam int DEN_W  = saia_pkg::DEN_W;
  localparam int DCNT_W = saia_pkg::DCNT_W;
  localparam int OUT_W  = saia_pkg::OUT_W;
  localparam int ND_W   = saia_pkg::CNT_W + 2;

  localparam logic [2:0] ST_ACC  = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]              state_q, state_d;
  logic signed [SUM_W-1:0] e_sum_q, e_sum_d, o_sum_q, o_sum_d, v_sum_q, v_sum_d;
  logic [DCNT_W-1:0]       cnt_q, cnt_d;

  logic signed [WGT_W-1:0] wgt_q, wgt_d;
  logic signed [WID_W-1:0] wid_q, wid_d;
  logic                    neg_q, neg_d;
  logic [WGT_W-1:0]        mw_q, mw_d;
  logic [WID_W-1:0]        mwid_q, mwid_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [NUM_W-1:0]        num_q, num_d;
  logic [DEN_W-1:0]        den_q, den_d, rem_q, rem_d;
  logic [OUT_W-1:0]        quo_q, quo_d;
  logic                    ovf_q, ovf_d;
  saia_pkg::res_t          res_q, res_d;

  logic signed [SUM_W-1:0] smp_ext;
  logic [ND_W-1:0]         nd;
  logic [DEN_W:0]          sh, diff;
  logic                    ge;
  logic [OUT_W-1:0]        limit, mag;
  logic                    sat;

  assign in_pop_o   = (state_q == ST_ACC) && !in_empty_i;
  assign res_push_o = (state_q == ST_DONE) && !out_full_i;
  assign res_o      = res_q;
  assign smp_ext    = SUM_W'(in_item_i.sample);

  assign nd    = cfg_i.mode ? ({1'b0, n_i, 1'b0} + {2'b00, n_i}) : {1'b0, n_i, 1'b0};
  assign sh    = {rem_q, num_q[NUM_W-1]};
  assign diff  = sh - {1'b0, den_q};
  assign ge    = (sh >= {1'b0, den_q});
  assign limit = neg_q ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  assign sat   = ovf_q || (quo_q > limit);
  assign mag   = sat ? limit : quo_q;

  always_comb begin
    state_d = state_q;
    e_sum_d = e_sum_q;
    o_sum_d = o_sum_q;
    v_sum_d = v_sum_q;
    cnt_d   = cnt_q;
    wgt_d   = wgt_q;
    wid_d   = wid_q;
    neg_d   = neg_q;
    mw_d    = mw_q;
    mwid_d  = mwid_q;
    prod_d  = prod_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    res_d   = res_q;
    case (state_q)
      ST_ACC: begin
        if (in_pop_o) begin
          case (in_item_i.cls)
            saia_pkg::CLS_END:  e_sum_d = e_sum_q + smp_ext;
            saia_pkg::CLS_ODD:  o_sum_d = o_sum_q + smp_ext;
            saia_pkg::CLS_EVEN: v_sum_d = v_sum_q + smp_ext;
            default: ;
          endcase
          if (in_item_i.last) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        wgt_d = WGT_W'(e_sum_q)
              + (cfg_i.mode ? (WGT_W'(o_sum_q) <<< 2) : (WGT_W'(o_sum_q) <<< 1))
              + (WGT_W'(v_sum_q) <<< 1);
        wid_d = WID_W'(cfg_i.upper) - WID_W'(cfg_i.lower);
        if (cfg_i.mode && n_i[0]) begin
          res_d.value = '0;
          res_d.err   = 1'b1;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        mw_d    = wgt_q[WGT_W-1] ? WGT_W'(-wgt_q) : WGT_W'(wgt_q);
        mwid_d  = wid_q[WID_W-1] ? WID_W'(-wid_q) : WID_W'(wid_q);
        neg_d   = wgt_q[WGT_W-1] ^ wid_q[WID_W-1];
        den_d   = {nd, 16'h0000};
        prod_d  = '0;
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = (prod_q << 1) + (mw_q[WGT_W-1] ? PROD_W'(mwid_q) : '0);
        mw_d   = mw_q << 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(WGT_W - 1)) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        num_d   = NUM_W'(prod_q) + NUM_W'(den_q >> 1);
        rem_d   = '0;
        quo_d   = '0;
        ovf_d   = 1'b0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        num_d = num_q << 1;
        quo_d = {quo_q[OUT_W-2:0], ge};
        ovf_d = ovf_q | quo_q[OUT_W-1];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(NUM_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        res_d.value = neg_q ? OUT_W'(-mag) : OUT_W'(mag);
        res_d.err   = 1'b0;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (res_push_o) begin
          e_sum_d = '0;
          o_sum_d = '0;
          v_sum_d = '0;
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      e_sum_q <= '0;
      o_sum_q <= '0;
      v_sum_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      e_sum_q <= e_sum_d;
      o_sum_q <= o_sum_d;
      v_sum_q <= v_sum_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wgt_q  <= wgt_d;
    wid_q  <= wid_d;
    neg_q  <= neg_d;
    mw_q   <= mw_d;
    mwid_q <= mwid_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    res_q  <= res_d;
  end

  `SAIA_ASSERT_NXT(a_clear_after_beat, res_push_o, (state_q == ST_ACC) && (e_sum_q == '0) && (o_sum_q == '0) && (v_sum_q == '0), "sums not cleared after result beat")
  `SAIA_ASSERT_IMP(a_err_zero_value, res_push_o && res_q.err, res_q.value == '0, "error result carries nonzero value")
  `SAIA_ASSERT_IMP(a_rem_below_den, state_q == ST_DIV, rem_q < den_q, "divider remainder not below divisor")

endmodule

// ===== hw/rtl/sampled_integral_accumulator.sv =====
`timescale 1ns / 1ps
// numerical integration of equally spaced Q16.16 samples, trapezoid or simpson rule
// config channel: cfg_valid_i/cfg_ready_o beat writes register cfg_index_i
//   (0 rule_mode, 1 lower_bound, 2 upper_bound, 3 interval_count); ready is always high
// input channel: a sample beat is taken when push is high and full is low
// result channel: oldest result on integral_value_o/count_error_o while empty is low,
//   taken when pop is high
// a run is n+1 samples; only the last one produces a result beat
// samples go through a 4-entry queue and are summed at one per cycle until the last
//   sample; then the back end takes no samples while it runs setup, a bit-serial
//   multiply, rounding, a restoring divide and saturation before the result beat;
//   an odd count in simpson mode skips the arithmetic and yields an error beat
// results wait in a 2-entry queue, so a stalled receiver only stops the back end
//   once that queue is full, and the input only once the sample queue is full
// reset clears the run state, both queues and loads the register defaults
//   (trapezoid, a = 0, b = 1.0, n = 2)
module sampled_integral_accumulator #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [saia_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [saia_pkg::CDAT_W-1:0]         cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic signed [saia_pkg::SMP_W-1:0]   sample_value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [saia_pkg::OUT_W-1:0]   integral_value_o,
  output logic                                count_error_o
);

  saia_pkg::cfg_t             cfg_q, cfg_d;
  logic [saia_pkg::CNT_W-1:0] n_eff;
  logic                       accept;
  saia_pkg::item_t            front_item, back_item;
  logic                       in_empty, in_pop;
  logic                       out_full, res_push;
  saia_pkg::res_t             res, out_res;

  assign cfg_ready_o = 1'b1;
  assign n_eff  = saia_pkg::eff_n(cfg_q.count, saia_pkg::MAXN_W'(MAX_INTERVALS));
  assign accept = push && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        saia_pkg::CFG_MODE:  cfg_d.mode  = cfg_data_i[0];
        saia_pkg::CFG_LOWER: cfg_d.lower = cfg_data_i;
        saia_pkg::CFG_UPPER: cfg_d.upper = cfg_data_i;
        saia_pkg::CFG_COUNT: cfg_d.count = cfg_data_i[saia_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= 1'b0;
      cfg_q.lower <= '0;
      cfg_q.upper <= saia_pkg::SMP_W'(65536);
      cfg_q.count <= saia_pkg::CNT_W'(2);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  saia_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_value_i),
    .n_i      (n_eff),
    .item_o   (front_item)
  );

  saia_fifo #(
    .WIDTH ($bits(saia_pkg::item_t)),
    .DEPTH (4)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_en_i (in_pop),
    .rdata_o (back_item),
    .empty_o (in_empty)
  );

  saia_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .n_i        (n_eff),
    .in_empty_i (in_empty),
    .in_item_i  (back_item),
    .in_pop_o   (in_pop),
    .out_full_i (out_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  saia_fifo #(
    .WIDTH ($bits(saia_pkg::res_t)),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (res_push),
    .wdata_i (res),
    .full_o  (out_full),
    .rd_en_i (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign integral_value_o = out_res.value;
  assign count_error_o    = out_res.err;

endmodule
